@@ hw/rtl/tefh_pkg.sv @@
// Shared constants, types, tables and rounding helpers of the temperature smoother.
package tefh_pkg;

	localparam int TEMP_FRAC_BITS = 8;
	localparam int ALPHA_BITS     = 16;
	localparam int EXTRA_BITS     = 8;
	localparam int RATIO_FRAC     = 10;
	localparam int STEP_BITS      = 5;
	localparam int TABLE_LEN      = 257;
	localparam int TAB_FRAC       = 30;
	localparam int TAB_W          = TAB_FRAC + 1;
	localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;

	localparam int TEMP_W    = 16;
	localparam int ELAPSED_W = 20;
	localparam int TAU_W     = 20;
	localparam int SMOOTH_W  = TEMP_W + EXTRA_BITS;
	localparam int DIFF_W    = SMOOTH_W + 1;
	localparam int DEG_W     = 9;
	localparam int RATIO_W   = RATIO_FRAC + 3;
	localparam int IDX_W     = RATIO_W - STEP_BITS;
	localparam int TIDX_W    = IDX_W + 1;
	localparam int ALPHA_W   = ALPHA_BITS + 1;
	localparam int ALPHA_SH  = TAB_FRAC - ALPHA_BITS;
	localparam int PROD_W    = DIFF_W + ALPHA_W;
	localparam int DIVD_W    = ELAPSED_W + RATIO_FRAC;
	localparam int CNT_W     = $clog2(RATIO_W);
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 2;
	localparam int DEG_SH    = TEMP_FRAC_BITS + EXTRA_BITS;
	localparam int DEG_MAX   = 255;
	localparam int DEG_MIN_MAG = 256;
	localparam int FILT_MAX  = 32767;
	localparam int FILT_MIN_MAG = 32768;

	localparam logic [CFG_IDX_W-1:0] REG_TAU         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FROST_ENTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FROST_EXIT  = 2'd2;

	typedef logic [TAB_W-1:0] exp_tab_t [TABLE_LEN];

	// exp(-k/32) in Q30, built by repeated multiplication with rounding.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] acc;
		t[0] = TAB_W'(64'd1 << TAB_FRAC);
		for (int k = 1; k < TABLE_LEN; k++) begin
			acc = 64'(t[k-1]) * EXP_STEP_Q30 + (64'd1 << (TAB_FRAC - 1));
			t[k] = TAB_W'(acc >> TAB_FRAC);
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// Whole degrees, rounded half away from zero and saturated to the 9 bit range.
	function automatic logic signed [DEG_W-1:0] deg_of(input logic signed [SMOOTH_W-1:0] s);
		logic neg;
		logic [SMOOTH_W-1:0] mag;
		logic [SMOOTH_W:0] r;
		logic signed [DEG_W-1:0] res;
		neg = s[SMOOTH_W-1];
		mag = neg ? SMOOTH_W'(-s) : SMOOTH_W'(s);
		r = ({1'b0, mag} + ((SMOOTH_W+1)'(1) << (DEG_SH - 1))) >> DEG_SH;
		if (!neg) begin
			res = (r > (SMOOTH_W+1)'(DEG_MAX)) ? DEG_W'(DEG_MAX) : DEG_W'(r);
		end else begin
			res = (r > (SMOOTH_W+1)'(DEG_MIN_MAG)) ? DEG_W'(-DEG_MIN_MAG)
				: DEG_W'((SMOOTH_W+1)'(0) - r);
		end
		return res;
	endfunction

	// Input units, rounded half away from zero and saturated to 16 bits.
	function automatic logic signed [TEMP_W-1:0] filt_of(input logic signed [SMOOTH_W-1:0] s);
		logic neg;
		logic [SMOOTH_W-1:0] mag;
		logic [SMOOTH_W:0] r;
		logic signed [TEMP_W-1:0] res;
		neg = s[SMOOTH_W-1];
		mag = neg ? SMOOTH_W'(-s) : SMOOTH_W'(s);
		r = ({1'b0, mag} + ((SMOOTH_W+1)'(1) << (EXTRA_BITS - 1))) >> EXTRA_BITS;
		if (!neg) begin
			res = (r > (SMOOTH_W+1)'(FILT_MAX)) ? TEMP_W'(FILT_MAX) : TEMP_W'(r);
		end else begin
			res = (r > (SMOOTH_W+1)'(FILT_MIN_MAG)) ? TEMP_W'(-FILT_MIN_MAG)
				: TEMP_W'((SMOOTH_W+1)'(0) - r);
		end
		return res;
	endfunction

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic lut;
		logic interp;
		logic alpha;
		logic mul;
		logic update;
		logic emit;
	} tefh_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic first;
		logic sat;
		logic div_last;
		logic out_free;
	} tefh_status_t;

endpackage

@@ hw/rtl/tefh_ctrl.sv @@
// Sequencer that steps one request through the smoothing datapath.
module tefh_ctrl
	import tefh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  tefh_status_t status,
	output tefh_cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PREP   = 9'b000000010,
		S_DIV    = 9'b000000100,
		S_LUT    = 9'b000001000,
		S_INTERP = 9'b000010000,
		S_ALPHA  = 9'b000100000,
		S_MUL    = 9'b001000000,
		S_UPD    = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				if (status.is_clear || status.first) begin
					state_d = S_UPD;
				end else if (status.sat) begin
					state_d = S_MUL;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_LUT;
				end
			end
			S_LUT: begin
				cmd.lut = 1'b1;
				state_d = S_INTERP;
			end
			S_INTERP: begin
				cmd.interp = 1'b1;
				state_d = S_ALPHA;
			end
			S_ALPHA: begin
				cmd.alpha = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/tefh_datapath.sv @@
// Registers, ratio divider, alpha table, update multiplier and result register.
module tefh_datapath
	import tefh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       action,
	input  logic signed [TEMP_W-1:0]   sample_temp,
	input  logic [ELAPSED_W-1:0]       elapsed_ms,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic signed [TEMP_W-1:0]   filtered_temp,
	output logic signed [DEG_W-1:0]    rounded_degrees,
	output logic                       reading_valid,
	output logic                       frost_warning,
	output logic                       temp_changed,
	output logic                       frost_changed,
	input  tefh_cmd_t                  cmd,
	output tefh_status_t               status
);

	logic [TAU_W-1:0]           tau_q;
	logic signed [TEMP_W-1:0]   frost_enter_q, frost_exit_q;
	logic signed [SMOOTH_W-1:0] smoothed_q;
	logic                       have_q, frost_q;

	logic                       action_q;
	logic signed [TEMP_W-1:0]   sample_q;
	logic [ELAPSED_W-1:0]       elapsed_q;

	logic [TAU_W-1:0]           rem_q;
	logic [RATIO_W-1:0]         dsr_q, quo_q;
	logic [CNT_W-1:0]           cnt_q;

	logic [TAB_W-1:0]           t0_q, t1_q;
	logic [STEP_BITS-1:0]       fr_q;
	logic [TAB_W+STEP_BITS-1:0] dprod_q;
	logic [ALPHA_W-1:0]         alpha_q;
	logic [PROD_W-1:0]          prod_q;
	logic                       dneg_q;
	logic                       tchg_q, fchg_q;
	logic                       out_valid_q;

	logic [DIVD_W-1:0]          dividend;
	logic [TAU_W:0]             shifted;
	logic                       take;
	logic                       sat;
	logic [IDX_W-1:0]           idx;
	logic [TAB_W-1:0]           e_val, a_val, a_rnd;
	logic signed [SMOOTH_W-1:0] v_ext;
	logic signed [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]          diff_mag;
	logic [PROD_W-1:0]          prod_rnd;
	logic [DIFF_W-1:0]          step_mag;
	logic signed [DIFF_W-1:0]   upd_sum;
	logic signed [SMOOTH_W-1:0] next_s;
	logic                       next_frost;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q         <= TAU_W'(30000);
			frost_enter_q <= TEMP_W'(768);
			frost_exit_q  <= TEMP_W'(1280);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TAU:         tau_q <= cfg_wdata[TAU_W-1:0];
				REG_FROST_ENTER: frost_enter_q <= cfg_wdata[TEMP_W-1:0];
				REG_FROST_EXIT:  frost_exit_q <= cfg_wdata[TEMP_W-1:0];
				default: ;
			endcase
		end
	end

	// Division of elapsed*1024 by tau; only needed when the ratio stays below its limit.
	assign dividend = {elapsed_q, RATIO_FRAC'(0)};
	assign shifted  = {rem_q, dsr_q[RATIO_W-1]};
	assign take     = shifted >= {1'b0, tau_q};
	assign sat      = (tau_q == '0) ||
		({3'b000, elapsed_q} >= {tau_q, 3'b000});

	assign idx   = quo_q[RATIO_W-1:STEP_BITS];
	assign e_val = t0_q - TAB_W'(dprod_q >> STEP_BITS);
	assign a_val = TAB_W'(64'd1 << TAB_FRAC) - e_val;
	assign a_rnd = (a_val + (TAB_W'(1) << (ALPHA_SH - 1))) >> ALPHA_SH;

	assign v_ext    = SMOOTH_W'(sample_q) <<< EXTRA_BITS;
	assign diff     = DIFF_W'(v_ext) - DIFF_W'(smoothed_q);
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign prod_rnd = (prod_q + (PROD_W'(1) << (ALPHA_BITS - 1))) >> ALPHA_BITS;
	assign step_mag = prod_rnd[DIFF_W-1:0];
	assign upd_sum  = DIFF_W'(smoothed_q) + (dneg_q ? DIFF_W'(-step_mag) : DIFF_W'(step_mag));

	always_comb begin
		if (!have_q) begin
			next_s = v_ext;
		end else begin
			next_s = upd_sum[SMOOTH_W-1:0];
		end
		if (next_s < (SMOOTH_W'(frost_enter_q) <<< EXTRA_BITS)) begin
			next_frost = 1'b1;
		end else if (next_s >= (SMOOTH_W'(frost_exit_q) <<< EXTRA_BITS)) begin
			next_frost = 1'b0;
		end else begin
			next_frost = frost_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action;
			sample_q  <= sample_temp;
			elapsed_q <= elapsed_ms;
		end
		if (cmd.prep) begin
			rem_q   <= TAU_W'(dividend[DIVD_W-1:RATIO_W]);
			dsr_q   <= dividend[RATIO_W-1:0];
			cnt_q   <= CNT_W'(RATIO_W - 1);
			alpha_q <= ALPHA_W'(1) << ALPHA_BITS;
		end
		if (cmd.div_step) begin
			rem_q <= take ? TAU_W'(shifted - {1'b0, tau_q}) : shifted[TAU_W-1:0];
			dsr_q <= dsr_q << 1;
			quo_q <= {quo_q[RATIO_W-2:0], take};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.lut) begin
			t0_q <= EXP_TAB[TIDX_W'(idx)];
			t1_q <= EXP_TAB[TIDX_W'(idx) + TIDX_W'(1)];
			fr_q <= quo_q[STEP_BITS-1:0];
		end
		if (cmd.interp) begin
			dprod_q <= (TAB_W+STEP_BITS)'(t0_q - t1_q) * (TAB_W+STEP_BITS)'(fr_q);
		end
		if (cmd.alpha) begin
			alpha_q <= a_rnd[ALPHA_W-1:0];
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(diff_mag) * PROD_W'(alpha_q);
			dneg_q <= diff[DIFF_W-1];
		end
		if (cmd.update) begin
			if (action_q) begin
				tchg_q <= have_q;
				fchg_q <= frost_q;
			end else begin
				tchg_q <= !have_q || (deg_of(smoothed_q) != deg_of(next_s));
				fchg_q <= next_frost != frost_q;
			end
		end
		if (cmd.emit) begin
			filtered_temp   <= have_q ? filt_of(smoothed_q) : '0;
			rounded_degrees <= have_q ? deg_of(smoothed_q) : '0;
			reading_valid   <= have_q;
			frost_warning   <= frost_q;
			temp_changed    <= tchg_q;
			frost_changed   <= fchg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q  <= '0;
			have_q      <= 1'b0;
			frost_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				if (action_q) begin
					smoothed_q <= '0;
					have_q     <= 1'b0;
					frost_q    <= 1'b0;
				end else begin
					smoothed_q <= next_s;
					have_q     <= 1'b1;
					frost_q    <= next_frost;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status.is_clear = action_q;
	assign status.first    = !have_q;
	assign status.sat      = sat;
	assign status.div_last = cnt_q == '0;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

@@ hw/rtl/temp_ema_frost_hysteresis.sv @@
// Top level of the time-constant temperature smoother with frost hysteresis.
//
// Input channel: in_valid/in_stall with action, sample_temp and elapsed_ms. A request
// is taken at a rising edge with in_valid high and in_stall low. Action 0 is a sample,
// action 1 clears the held reading and the frost flag.
// Output channel: out_valid/out_stall, one result per request, held steady while
// out_stall is high. The result register lets the next request be accepted while a
// finished result still waits.
// Configuration: cfg_we with cfg_index (0 tau_ms, 1 frost_enter, 2 frost_exit) and
// cfg_wdata. The user must write them only while the block is idle; the block itself
// does not enforce this. Sequence: a clear or the first sample after reset or clear
// passes the prepare and update steps; a sample whose elapsed time is eight time
// constants or more, or any sample with tau_ms zero, also passes the multiply; any other
// sample first runs the bit-serial division of elapsed_ms by tau_ms that forms the
// table index, then lookup, interpolation and alpha. One request is in flight at a time.
// Reset restores the register defaults and drops the reading and the frost flag.
// A stalled output holds the block in its last step until the result register frees.
module temp_ema_frost_hysteresis
	import tefh_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic signed [TEMP_W-1:0]   sample_temp,
	input  logic [ELAPSED_W-1:0]       elapsed_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [TEMP_W-1:0]   filtered_temp,
	output logic signed [DEG_W-1:0]    rounded_degrees,
	output logic                       reading_valid,
	output logic                       frost_warning,
	output logic                       temp_changed,
	output logic                       frost_changed
);

	// The controller issues one command per cycle except while idle or waiting to emit;
	// the datapath reports back the facts that steer the sequence (clear, first sample,
	// saturated alpha, divider end, and whether the result register can take a new result).
	tefh_cmd_t    cmd;
	tefh_status_t status;

	tefh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tefh_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.action          (action),
		.sample_temp     (sample_temp),
		.elapsed_ms      (elapsed_ms),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.filtered_temp   (filtered_temp),
		.rounded_degrees (rounded_degrees),
		.reading_valid   (reading_valid),
		.frost_warning   (frost_warning),
		.temp_changed    (temp_changed),
		.frost_changed   (frost_changed),
		.cmd             (cmd),
		.status          (status)
	);

endmodule

@@ hw/rtl/tefh_checker.sv @@
// Port-level checker of the temperature smoother and its bind to the top level.
module tefh_checker
	import tefh_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [TEMP_W-1:0] filtered_temp,
	input logic signed [DEG_W-1:0]  rounded_degrees,
	input logic                     reading_valid,
	input logic                     frost_warning
);

	// A pending result stays offered while stalled.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(filtered_temp) && $stable(rounded_degrees))
		else $error("stalled result changed");

	// One request at a time: right after an accept the input side is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while one is in flight");

	// Without a reading the value fields are zero and no frost is flagged.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reading_valid |->
		filtered_temp == '0 && rounded_degrees == '0 && !frost_warning)
		else $error("empty reading carries a value or frost");

endmodule

bind temp_ema_frost_hysteresis tefh_checker u_tefh_checker (.*);

@@ sim/temp_ema_frost_hysteresis_tb.sv @@
// Self-checking testbench for the temperature smoother with frost hysteresis.
`timescale 1ns / 1ps

module temp_ema_frost_hysteresis_tb;
	import tefh_pkg::*;

	// Alpha of exactly one, and the ratio of elapsed time to tau (Q10) at which alpha
	// saturates: eight time constants.
	localparam longint ALPHA_ONE  = 64'sd1 << ALPHA_BITS;
	localparam longint RATIO_SAT  = 64'sd8 << RATIO_FRAC;
	localparam int     ELAPSED_MAX = (1 << ELAPSED_W) - 1;

	// One expected result. The temperature fields are kept unsigned here and
	// sign-extended where they are compared.
	typedef struct packed {
		logic [TEMP_W-1:0] filt;
		logic [DEG_W-1:0]  deg;
		logic              held;
		logic              frost;
		logic              temp_moved;
		logic              frost_moved;
	} reading_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_TAU;
	logic [CFG_W-1:0]         cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     action = 1'b0;
	logic signed [TEMP_W-1:0] sample_temp = '0;
	logic [ELAPSED_W-1:0]     elapsed_ms = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [TEMP_W-1:0] filtered_temp;
	logic signed [DEG_W-1:0]  rounded_degrees;
	logic                     reading_valid;
	logic                     frost_warning;
	logic                     temp_changed;
	logic                     frost_changed;

	// The smoother's own state and register copies, as the testbench sees them.
	longint unsigned          exp_q30 [TABLE_LEN];
	longint                   smoothed_acc;
	logic                     held_reading;
	logic                     frost_state;
	logic [TAU_W-1:0]         tau_setting;
	logic signed [TEMP_W-1:0] enter_setting;
	logic signed [TEMP_W-1:0] exit_setting;

	// Readings predicted for accepted requests, oldest first.
	reading_t                 expected_readings [$];

	// Idle rates in percent per cycle for the request side and the result side.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	int mismatch_count = 0;
	int requests_sent = 0;
	int clears_sent = 0;
	int results_checked = 0;
	int frost_toggles = 0;
	int settings_applied = 0;
	int setting_round = 0;

	temp_ema_frost_hysteresis DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.sample_temp     (sample_temp),
		.elapsed_ms      (elapsed_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.filtered_temp   (filtered_temp),
		.rounded_degrees (rounded_degrees),
		.reading_valid   (reading_valid),
		.frost_warning   (frost_warning),
		.temp_changed    (temp_changed),
		.frost_changed   (frost_changed)
	);

	always #5 clk = ~clk;

	// The table holds exp(-k/32) in Q30. Each entry is the previous one times
	// exp(-1/32), rounded to nearest.
	function automatic void build_exp_table();
		exp_q30[0] = 64'd1 << TAB_FRAC;
		for (int k = 1; k < TABLE_LEN; k++) begin
			exp_q30[k] = (exp_q30[k-1] * 64'd1040706261 + (64'd1 << (TAB_FRAC - 1)))
				>> TAB_FRAC;
		end
	endfunction

	function automatic longint round_half_away(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'sd1 << (sh - 1))) >> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	// Whole degrees of the smoothed value, saturated to the 9 bit output range.
	function automatic longint degrees_of(longint s);
		longint r;
		r = round_half_away(s, TEMP_FRAC_BITS + EXTRA_BITS);
		if (r > 255)
			r = 255;
		if (r < -256)
			r = -256;
		return r;
	endfunction

	// Alpha in Q16 for a given elapsed time: the elapsed/tau ratio indexes the
	// exp table, the step between two entries is interpolated with truncation,
	// and one minus the result is rounded half up.
	function automatic longint alpha_q16(logic [ELAPSED_W-1:0] el);
		longint unsigned ratio, e, a, fr;
		int idx;
		if (tau_setting == 0)
			return ALPHA_ONE;
		ratio = (longint'(el) << RATIO_FRAC) / longint'(tau_setting);
		if (ratio >= RATIO_SAT)
			return ALPHA_ONE;
		idx = int'(ratio >> STEP_BITS);
		fr = ratio & ((64'd1 << STEP_BITS) - 1);
		e = exp_q30[idx] - (((exp_q30[idx] - exp_q30[idx+1]) * fr) >> STEP_BITS);
		a = (64'd1 << TAB_FRAC) - e;
		return longint'((a + (64'd1 << (ALPHA_SH - 1))) >> ALPHA_SH);
	endfunction

	// Advances the smoother by one request and returns the reading it reports.
	function automatic reading_t smoother_step(logic act, logic signed [TEMP_W-1:0] t,
		logic [ELAPSED_W-1:0] el);
		reading_t r;
		longint target, prev_deg, f;
		logic first, prev_frost;
		r = '0;
		if (act) begin
			// A clear only reports the changes it actually makes.
			if (held_reading) begin
				held_reading = 1'b0;
				smoothed_acc = 0;
				r.temp_moved = 1'b1;
			end
			if (frost_state) begin
				frost_state = 1'b0;
				r.frost_moved = 1'b1;
			end
		end else begin
			target = longint'(t) <<< EXTRA_BITS;
			first = !held_reading;
			prev_deg = degrees_of(smoothed_acc);
			prev_frost = frost_state;
			if (first) begin
				smoothed_acc = target;
				held_reading = 1'b1;
			end else begin
				smoothed_acc = smoothed_acc + round_half_away(
					(target - smoothed_acc) * alpha_q16(el), ALPHA_BITS);
			end
			// Enter wins over exit when the two thresholds overlap.
			if (smoothed_acc < (longint'(enter_setting) <<< EXTRA_BITS))
				frost_state = 1'b1;
			else if (smoothed_acc >= (longint'(exit_setting) <<< EXTRA_BITS))
				frost_state = 1'b0;
			r.frost_moved = frost_state != prev_frost;
			r.temp_moved = first || (prev_deg != degrees_of(smoothed_acc));
		end
		if (held_reading) begin
			f = round_half_away(smoothed_acc, EXTRA_BITS);
			if (f > 32767)
				f = 32767;
			if (f < -32768)
				f = -32768;
			r.filt = TEMP_W'(f);
			r.deg = DEG_W'(degrees_of(smoothed_acc));
		end
		r.held = held_reading;
		r.frost = frost_state;
		return r;
	endfunction

	function automatic void compare_field(string name, logic signed [31:0] want,
		logic signed [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// Offers one request after a random gap and holds it until it is taken. The
	// reading is predicted at the edge that accepts the request. The valid line is
	// left high so that a following request can go out back to back.
	task automatic send_request(logic act, logic signed [TEMP_W-1:0] t,
		logic [ELAPSED_W-1:0] el);
		reading_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample_temp <= t;
		elapsed_ms <= el;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = smoother_step(act, t, el);
		if (r.frost_moved)
			frost_toggles++;
		if (act)
			clears_sent++;
		requests_sent++;
		expected_readings.push_back(r);
	endtask

	// Drops the request line and waits until every predicted reading has come back.
	// Since every request makes exactly one result, the block is idle then.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
	endtask

	// Writes all three registers on consecutive edges while the block is idle. The
	// upper bits of the threshold words carry noise that the block must ignore.
	task automatic apply_settings(logic [TAU_W-1:0] tau, logic signed [TEMP_W-1:0] enter,
		logic signed [TEMP_W-1:0] leave);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= REG_TAU;
		cfg_wdata <= tau;
		@(posedge clk);
		cfg_index <= REG_FROST_ENTER;
		cfg_wdata <= {4'($urandom), enter};
		@(posedge clk);
		cfg_index <= REG_FROST_EXIT;
		cfg_wdata <= {4'($urandom), leave};
		@(posedge clk);
		cfg_we <= 1'b0;
		tau_setting = tau;
		enter_setting = enter;
		exit_setting = leave;
		settings_applied++;
	endtask

	function automatic logic signed [TEMP_W-1:0] clamp_temp(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return TEMP_W'(v);
	endfunction

	// Steps through a list of register settings that holds the extremes, then
	// picks random ones with exit at or above enter.
	task automatic next_settings();
		int enter;
		enter = int'($urandom_range(16000)) - 8000;
		case (setting_round % 8)
			0: apply_settings(20'd30000, 16'sd768, 16'sd1280);
			1: apply_settings(20'd1, -16'sd32768, 16'sd32767);
			2: apply_settings(20'hFFFFF, 16'sd32767, -16'sd32768);
			3: apply_settings(20'd500, -16'sd2560, -16'sd1280);
			4: apply_settings(20'd60000, 16'sd0, 16'sd0);
			5: apply_settings(20'd7, 16'sd1000, 16'sd3000);
			6: apply_settings(20'($urandom_range(ELAPSED_MAX, 1)), clamp_temp(enter),
				clamp_temp(enter + int'($urandom_range(2048))));
			default: apply_settings(20'($urandom_range(100000, 1)), clamp_temp(enter),
				clamp_temp(enter + int'($urandom_range(2048))));
		endcase
		setting_round++;
	endtask

	// Mostly samples aimed where the behavior is interesting: around the frost
	// thresholds, near the current reading and on half-degree boundaries, with
	// elapsed times spread around tau. A few clears break the sequences up.
	task automatic random_request();
		int pick, t;
		longint span;
		logic [ELAPSED_W-1:0] el;
		pick = $urandom_range(99);
		if (pick < 4) begin
			send_request(1'b1, TEMP_W'($urandom), ELAPSED_W'($urandom));
		end else begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				t = ($urandom_range(1) ? int'(enter_setting) : int'(exit_setting))
					+ int'($urandom_range(1024)) - 512;
			end else if (pick < 65) begin
				t = int'(smoothed_acc >>> EXTRA_BITS) + int'($urandom_range(1536)) - 768;
			end else if (pick < 85) begin
				t = int'($signed(TEMP_W'($urandom)));
			end else begin
				t = (int'($urandom_range(255)) - 128) * 256 + 128
					+ int'($urandom_range(2)) - 1;
			end
			pick = $urandom_range(99);
			span = 2 * longint'(tau_setting);
			if (span > ELAPSED_MAX)
				span = ELAPSED_MAX;
			if (pick < 10)
				el = '0;
			else if (pick < 50)
				el = ELAPSED_W'($urandom_range(int'(span)));
			else if (pick < 65)
				el = ELAPSED_W'($urandom_range(63));
			else if (pick < 80 || 8 * longint'(tau_setting) > ELAPSED_MAX)
				el = ELAPSED_W'($urandom);
			else
				el = ELAPSED_W'($urandom_range(ELAPSED_MAX, 8 * int'(tau_setting)));
			send_request(1'b0, clamp_temp(t), el);
		end
	endtask

	task automatic run_traffic(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 90 == 0)
				next_settings();
			random_request();
		end
	endtask

	// Special cases with the reset defaults first, then with a zero time constant
	// and with the tightest time constant and crossed thresholds.
	task automatic test_directed();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		send_request(1'b1, 16'sd0, 20'd0);             // clear with nothing held
		send_request(1'b0, 16'sd32767, 20'd0);         // seed at the top of the range
		send_request(1'b0, -16'sd32768, 20'd0);        // no time passed, no movement
		send_request(1'b0, -16'sd32768, 20'hFFFFF);    // saturated alpha, frost on
		send_request(1'b0, 16'sd0, 20'd30000);         // one time constant
		send_request(1'b1, 16'sd0, 20'd0);             // clear drops reading and frost
		send_request(1'b1, 16'sd0, 20'd0);             // second clear changes nothing
		send_request(1'b0, 16'sd128, 20'd0);           // half a degree rounds up
		send_request(1'b1, -16'sd1, 20'hFFFFF);
		send_request(1'b0, -16'sd128, 20'd0);          // minus half rounds away from zero
		send_request(1'b0, 16'sd1000, 20'd240000);     // exactly eight tau, inside band
		send_request(1'b0, 16'sd1280, 20'd240000);     // at the exit threshold
		send_request(1'b0, 16'sd767, 20'd300000);      // just below the enter threshold
		send_request(1'b0, 16'sd1279, 20'd0);          // hysteresis checked on zero time
		send_request(1'b0, 16'sd5000, 20'd15000);
		send_request(1'b0, 16'sd5000, 20'd1);
		apply_settings(20'd0, -16'sd32768, 16'sd32767);
		send_request(1'b0, -16'sd100, 20'd0);          // zero tau takes the sample as is
		send_request(1'b0, 16'sd32767, 20'd5);
		apply_settings(20'd1, 16'sd32767, -16'sd32768);
		send_request(1'b0, 16'sd1000, 20'd7);          // interpolated near the table end
		send_request(1'b0, -16'sd32768, 20'd8);        // ratio reaches the limit
		send_request(1'b0, 16'sd255, 20'd1);
		apply_settings(20'd30000, 16'sd768, 16'sd1280);
	endtask

	// Results are the bottleneck: the receiver stalls often.
	task automatic test_slow_sink();
		send_gap_pct = 12;
		recv_stall_pct = 48;
		run_traffic(370);
	endtask

	// Requests are the bottleneck: the sender leaves many gaps.
	task automatic test_slow_source();
		send_gap_pct = 48;
		recv_stall_pct = 12;
		run_traffic(370);
	endtask

	// Neither side idles, so requests follow each other as fast as the block allows.
	task automatic test_full_rate();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_traffic(370);
	endtask

	// Every accepted result is matched against the oldest predicted reading. The
	// result-side stall is redrawn on every edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				$display("%0t ns: result with no request outstanding, expected none, got %0d",
					$time, filtered_temp);
			end else begin
				compare_field("filtered_temp", $signed(expected_readings[0].filt),
					filtered_temp);
				compare_field("rounded_degrees", $signed(expected_readings[0].deg),
					rounded_degrees);
				compare_field("reading_valid", expected_readings[0].held, reading_valid);
				compare_field("frost_warning", expected_readings[0].frost, frost_warning);
				compare_field("temp_changed", expected_readings[0].temp_moved, temp_changed);
				compare_field("frost_changed", expected_readings[0].frost_moved,
					frost_changed);
				void'(expected_readings.pop_front());
				results_checked++;
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Main sequence: reset, the directed cases, then three random phases that
	// differ in which side idles.
	initial begin
		build_exp_table();
		smoothed_acc = 0;
		held_reading = 1'b0;
		frost_state = 1'b0;
		tau_setting = 20'd30000;
		enter_setting = 16'sd768;
		exit_setting = 16'sd1280;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_slow_sink();
		test_slow_source();
		test_full_rate();
		wait_idle();
		// Give a stray late result time to show up.
		repeat (30) @(posedge clk);
		$display("Covered %0d requests (%0d clears, %0d frost changes) under %0d settings,",
			requests_sent, clears_sent, frost_toggles, settings_applied);
		$display("with %0d results compared and %0d mismatches.", results_checked,
			mismatch_count);
		if (mismatch_count == 0)
			$display("temp_ema_frost_hysteresis_tb: clean");
		else
			$display("temp_ema_frost_hysteresis_tb: errors");
		$finish;
	end

	// A run that hangs ends here.
	initial begin
		#5000000;
		$display("temp_ema_frost_hysteresis_tb: errors");
		$finish;
	end

endmodule
